### hdl/largest_prime_factor_top_assert.svh
// assertion macros used by the checker file
`ifndef LARGEST_PRIME_FACTOR_TOP_ASSERT_SVH
`define LARGEST_PRIME_FACTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LPF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define LPF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/lpf_pkg.sv
package lpf_pkg;

    // bits of the number to factor and of the result
    localparam int VALUE_WIDTH = 31;

    // divider step counter width
    localparam int STEP_W = $clog2(VALUE_WIDTH);

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture a new input beat
        logic div_init;  // start a division of the remainder by the divisor
        logic div_step;  // one restoring division step
        logic take;      // divisor divides: remainder becomes the quotient
        logic advance;   // divisor does not divide: move to the next candidate
        logic load_out;  // copy the remainder into the result register
    } lpf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic q_below_d; // divisor exceeds quotient: search is over
        logic rem_zero;  // division left no remainder
    } lpf_stat_t;

endpackage

### hdl/lpf_ctrl.sv
module lpf_ctrl import lpf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  lpf_stat_t stat,
    output lpf_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic              m_valid_reg, m_valid_next;

    // state, step counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // next state and command decode
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init  = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_cnt_reg == STEP_W'(VALUE_WIDTH - 1)) begin
                    state_next = ST_DECIDE;
                end else begin
                    step_cnt_next = step_cnt_reg + STEP_W'(1);
                end
            end
            ST_DECIDE: begin
                if (stat.q_below_d) begin
                    state_next = ST_DONE;
                end else begin
                    if (stat.rem_zero) begin
                        cmd.take = 1'b1;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### hdl/lpf_datapath.sv
module lpf_datapath import lpf_pkg::*; (
    input  logic                   aclk,
    input  lpf_cmd_t               cmd,
    input  logic [VALUE_WIDTH-1:0] in_value,
    output lpf_stat_t              stat,
    output logic [VALUE_WIDTH-1:0] result_value
);

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH+1:0] diff;

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    // restoring divider trial subtract
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, d_reg};

    always_comb begin
        n_next   = n_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        res_next = res_reg;

        // new beat: zero behaves as one, divisor starts at two
        if (cmd.load) begin
            n_next = (in_value < VALUE_WIDTH'(2)) ? VALUE_WIDTH'(1) : in_value;
            d_next = VALUE_WIDTH'(2);
        end

        // division of remainder by divisor, one quotient bit a cycle
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = n_reg;
        end
        if (cmd.div_step) begin
            if (diff[VALUE_WIDTH+1]) begin
                rem_next = shifted[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end else begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
        end

        // divide out a factor or move to the next odd candidate
        if (cmd.take) begin
            n_next = quo_reg;
        end
        if (cmd.advance) begin
            d_next = (d_reg == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3) : d_reg + VALUE_WIDTH'(2);
        end

        // what is left once the divisor passes its square root is the answer
        if (cmd.load_out) begin
            res_next = n_reg;
        end
    end

    assign stat.q_below_d = (d_reg > quo_reg);
    assign stat.rem_zero  = (rem_reg == '0);
    assign result_value   = res_reg;

endmodule

### hdl/largest_prime_factor_top.sv
// channel  | valid   | ready   | payload
// ---------+---------+---------+------------------------------
// input    | s_valid | s_ready | s_value[VALUE_WIDTH-1:0]
// result   | m_valid | m_ready | m_largest_factor[VALUE_WIDTH-1:0]
//
// one beat in flight: IDLE accepts it, each trial divisor then passes through
// DIV_INIT, DIV and DECIDE in the bit-serial restoring divider, and DONE hands
// the result over; the longest search is for a 31-bit prime near 2^31.
// synchronous active-low reset clears the controller and result valid.
// a stalled result sits in the output register; the next beat is accepted meanwhile.
module largest_prime_factor_top import lpf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_largest_factor
);

    lpf_cmd_t  cmd;
    lpf_stat_t stat;

    // sequencer
    lpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // remainder, divisor, divider and result registers
    lpf_datapath u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .in_value     (s_value),
        .stat         (stat),
        .result_value (m_largest_factor)
    );

endmodule

### hdl/lpf_checker.sv
`include "largest_prime_factor_top_assert.svh"

module lpf_checker import lpf_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [VALUE_WIDTH-1:0] s_value,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [VALUE_WIDTH-1:0] m_largest_factor
);

    // a stalled result beat holds its value
    `LPF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_largest_factor))

    // a result is never zero
    `LPF_ASSERT_IMPLY(a_out_nonzero, aclk, aresetn, m_valid, m_largest_factor != '0)

    // busy in the cycle after taking a beat
    `LPF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a beat taken while no result is pending gives no immediate result
    `LPF_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid)

endmodule

bind largest_prime_factor_top lpf_checker u_lpf_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_value          (s_value),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_largest_factor (m_largest_factor)
);

### tb/sv/testbench.sv
module testbench import lpf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // one outstanding factorisation: the number sent and its largest prime factor
    typedef struct {
        value_t value;
        value_t factor;
    } factor_expect_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    value_t s_value = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    value_t m_largest_factor;

    factor_expect_t pending_factors[$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_left = 0;

    largest_prime_factor_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_largest_factor (m_largest_factor)
    );

    // clock
    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // trial division: strip each divisor while it divides, stop at the square root
    function automatic value_t largest_prime_of(input value_t number);
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned best;
        rest = number;
        divisor = 2;
        best = 1;
        if (rest < 2)
            return value_t'(1);
        while (divisor <= rest / divisor) begin
            if (rest % divisor == 0) begin
                best = divisor;
                rest = rest / divisor;
            end else begin
                divisor = (divisor == 2) ? 3 : divisor + 2;
            end
        end
        if (rest > 1)
            best = rest;
        return best[VALUE_WIDTH-1:0];
    endfunction

    // product of random factors up to 255, so it factors quickly at any magnitude
    function automatic value_t smooth_value();
        longint unsigned acc;
        longint unsigned next;
        int              tries;
        acc = 1;
        for (tries = 0; tries < 40; tries++) begin
            next = acc * $urandom_range(255, 2);
            if (next > VALUE_MAX)
                break;
            acc = next;
            if ($urandom_range(15) == 0)
                break;
        end
        return acc[VALUE_WIDTH-1:0];
    endfunction

    // random number mix: small raw values, shifted small values, smooth products
    function automatic value_t random_value();
        int unsigned pick;
        value_t      shifted;
        pick = $urandom_range(99);
        shifted = value_t'($urandom_range(255));
        if (pick < 30)
            return value_t'($urandom_range(4095));
        else if (pick < 40)
            return shifted << $urandom_range(VALUE_WIDTH - 8);
        else
            return smooth_value();
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // offer one beat, with random idle cycles in front, and wait for its acceptance
    task automatic send_value(input value_t number);
        factor_expect_t entry;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= number;
        do
            @(posedge aclk);
        while (!s_ready);
        entry.value = number;
        entry.factor = largest_prime_of(number);
        pending_factors.push_back(entry);
    endtask

    // sender goes quiet until every result is back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_factors.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random_values(input int count);
        repeat (count)
            send_value(random_value());
        wait_for_results();
    endtask

    task automatic test_zero_and_one();
        send_value('0);
        send_value(value_t'(1));
        wait_for_results();
    endtask

    task automatic test_primes();
        send_value(value_t'(2));
        send_value(value_t'(3));
        send_value(value_t'(13));
        send_value(value_t'(4093));
        send_value(value_t'(65521));
        // all ones is prime at this width: longest search the block can see
        send_value(value_t'(VALUE_MAX));
        wait_for_results();
    endtask

    task automatic test_composites();
        send_value(value_t'(4));
        send_value(value_t'(9));
        send_value(value_t'(49));
        send_value(value_t'(30030));
        send_value(value_t'(63001));
        send_value(value_t'(3072));
        send_value(value_t'(1) << (VALUE_WIDTH - 1));
        send_value(value_t'((64'd1 << (VALUE_WIDTH - 1)) + 64'd1));
        send_value(value_t'(VALUE_MAX - 64'd1));
        send_value(value_t'(2048 * 2039));
        wait_for_results();
    endtask

    task automatic test_random_no_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_values(25);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 76;
        recv_stall_pct = 0;
        send_random_values(25);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct = 0;
        recv_stall_pct = 76;
        send_random_values(25);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct = 34;
        recv_stall_pct = 34;
        send_random_values(25);
    endtask

    // receiver holds off while the sender keeps offering: result and input both back up
    task automatic test_receiver_hold_off();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (5)
            send_value(value_t'($urandom_range(4095, 2)));
        wait_for_results();
    endtask

    // result ready: long hold-off first, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        factor_expect_t entry;
        if (aresetn && m_valid && m_ready) begin
            if (pending_factors.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected",
                                          m_largest_factor));
            end else begin
                entry = pending_factors.pop_front();
                if (m_largest_factor !== entry.factor)
                    report_mismatch($sformatf("value %0d: largest factor %0d, expected %0d",
                                              entry.value, m_largest_factor, entry.factor));
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk) cycle_count++;
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES)
            @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_and_one();
        test_primes();
        test_composites();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_receiver_hold_off();

        repeat (SETTLE_CYCLES)
            @(posedge aclk);
        if (pending_factors.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_factors.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### largest_prime_factor_top.f
+incdir+hdl
hdl/lpf_pkg.sv
hdl/lpf_ctrl.sv
hdl/lpf_datapath.sv
hdl/largest_prime_factor_top.sv
hdl/lpf_checker.sv
tb/sv/testbench.sv
